// ----- sv/size_class_pool_allocator_assert.svh -----
// assertion macros shared by the pool allocator modules
`ifndef SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_ASSERT_SVH

// condition holds at every edge out of reset
`define SCPA_ASSERT_ALWAYS(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SCPA_ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent holds in the cycle after the antecedent
`define SCPA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/scpa_pkg.sv -----
// shared types, constants and helper functions of the size class pool allocator
package scpa_pkg;

    localparam int BASE_BLOCKS_DEF     = 4096;
    localparam int NUM_CLASSES_DEF     = 5;
    localparam int MIN_BLOCK_BYTES_DEF = 32;
    localparam int NUM_TAGS_DEF        = 16;

    localparam int SIZE_W    = 12;
    localparam int TAG_IN_W  = 4;
    localparam int IDX_OUT_W = 12;
    localparam int CLS_OUT_W = 3;
    localparam int LEFT_W    = 13;
    localparam int BYTE_W    = 20;
    localparam int STATUS_W  = 3;
    localparam int GRANT_W   = 32;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ALLOC     = 3'd0,
        STATUS_EXHAUSTED = 3'd1,
        STATUS_TOO_LARGE = 3'd2,
        STATUS_FREED     = 3'd3,
        STATUS_BAD_INDEX = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CTRL_CLEAR,
        CTRL_IDLE,
        CTRL_EXEC,
        CTRL_POP
    } ctrl_state_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic read_link;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic need_pop;
        logic out_free;
    } dp_status_t;

    function automatic int class_count(input int base_blocks, input int cls);
        return base_blocks >> cls;
    endfunction

    function automatic int class_base(input int base_blocks, input int cls);
        int off;
        off = 0;
        for (int k = 0; k < cls; k++) begin
            off += base_blocks >> k;
        end
        return off;
    endfunction

    function automatic int link_depth(input int base_blocks, input int num_classes);
        return class_base(base_blocks, num_classes);
    endfunction

endpackage

// ----- sv/scpa_ctrl.sv -----
// controller state machine: link clearing pass, request sequencing and result hand-off
`include "size_class_pool_allocator_assert.svh"

module scpa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  scpa_pkg::dp_status_t sts,
    output scpa_pkg::dp_cmd_t    cmd
);

    scpa_pkg::ctrl_state_t state_reg;
    scpa_pkg::ctrl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scpa_pkg::CTRL_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            scpa_pkg::CTRL_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_last) begin
                    state_next = scpa_pkg::CTRL_IDLE;
                end
            end
            scpa_pkg::CTRL_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = scpa_pkg::CTRL_EXEC;
                end
            end
            scpa_pkg::CTRL_EXEC: begin
                // a granted pop needs the head's link out of the memory first
                if (sts.need_pop) begin
                    cmd.read_link = 1'b1;
                    state_next    = scpa_pkg::CTRL_POP;
                end else if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = scpa_pkg::CTRL_IDLE;
                end
            end
            scpa_pkg::CTRL_POP: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = scpa_pkg::CTRL_IDLE;
                end
            end
            default: begin
                state_next = scpa_pkg::CTRL_CLEAR;
            end
        endcase
    end

    `SCPA_ASSERT_NEXT(a_clear_once, aclk, aresetn, state_reg != scpa_pkg::CTRL_CLEAR, state_reg != scpa_pkg::CTRL_CLEAR, "clearing pass entered again after it finished")
    `SCPA_ASSERT_IMPLIES(a_pop_after_exec, aclk, aresetn, state_reg == scpa_pkg::CTRL_POP, $past(state_reg) == scpa_pkg::CTRL_EXEC || $past(state_reg) == scpa_pkg::CTRL_POP, "pop state reached without a link read")

endmodule

// ----- sv/scpa_dp.sv -----
// datapath: request registers, free list heads, link memory, byte counters, result register
`include "size_class_pool_allocator_assert.svh"

module scpa_dp #(
    parameter int BASE_BLOCKS     = scpa_pkg::BASE_BLOCKS_DEF,
    parameter int NUM_CLASSES     = scpa_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_BYTES = scpa_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int NUM_TAGS        = scpa_pkg::NUM_TAGS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  scpa_pkg::dp_cmd_t                cmd,
    output scpa_pkg::dp_status_t             sts,
    input  logic                             s_req_type,
    input  logic [scpa_pkg::SIZE_W-1:0]      s_req_size,
    input  logic [scpa_pkg::TAG_IN_W-1:0]    s_usage_tag,
    input  logic [scpa_pkg::IDX_OUT_W-1:0]   s_free_index,
    input  logic                             m_ready,
    output logic                             m_valid,
    output logic [scpa_pkg::STATUS_W-1:0]    m_status,
    output logic [scpa_pkg::CLS_OUT_W-1:0]   m_block_class,
    output logic [scpa_pkg::IDX_OUT_W-1:0]   m_block_index,
    output logic [scpa_pkg::LEFT_W-1:0]      m_blocks_left,
    output logic [scpa_pkg::BYTE_W-1:0]      m_used_bytes,
    output logic [scpa_pkg::BYTE_W-1:0]      m_peak_bytes,
    output logic [scpa_pkg::BYTE_W-1:0]      m_tag_bytes
);

    localparam int IDX_W      = $clog2(BASE_BLOCKS);
    localparam int CNT_W      = $clog2(BASE_BLOCKS + 1);
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int TAG_W      = (NUM_TAGS > 1) ? $clog2(NUM_TAGS) : 1;
    localparam int LINK_DEPTH = scpa_pkg::link_depth(BASE_BLOCKS, NUM_CLASSES);
    localparam int SLOT_W     = (LINK_DEPTH > 1) ? $clog2(LINK_DEPTH) : 1;
    localparam int BYTE_W     = scpa_pkg::BYTE_W;
    localparam int SUM_W      = scpa_pkg::BYTE_W + 1;

    // per class constants
    logic [CNT_W-1:0]  count_tab [NUM_CLASSES];
    logic [SLOT_W-1:0] base_tab  [NUM_CLASSES];

    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_tab
        assign count_tab[g] = CNT_W'(scpa_pkg::class_count(BASE_BLOCKS, g));
        assign base_tab[g]  = SLOT_W'(scpa_pkg::class_base(BASE_BLOCKS, g));
    end

    // request registers
    logic                           req_type_reg;
    logic [scpa_pkg::SIZE_W-1:0]    req_size_reg;
    logic [scpa_pkg::TAG_IN_W-1:0]  tag_reg;
    logic [scpa_pkg::IDX_OUT_W-1:0] fidx_reg;
    logic [CLS_W-1:0]               cls_reg;
    logic                           found_reg;
    logic [CLS_W-1:0]               sel_cls;
    logic                           sel_found;

    // smallest class whose block size covers the request
    always_comb begin
        sel_cls   = '0;
        sel_found = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (32'(s_req_size) <= (32'(MIN_BLOCK_BYTES) << c)) begin
                sel_cls   = CLS_W'(c);
                sel_found = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_type_reg <= s_req_type;
            req_size_reg <= s_req_size;
            tag_reg      <= s_usage_tag;
            fidx_reg     <= s_free_index;
            cls_reg      <= sel_cls;
            found_reg    <= sel_found;
        end
    end

    // allocator state
    logic [IDX_W-1:0]          head_reg      [NUM_CLASSES];
    logic                      head_ok_reg   [NUM_CLASSES];
    logic [CNT_W-1:0]          fb_reg        [NUM_CLASSES];
    logic [BYTE_W-1:0]         used_reg;
    logic [BYTE_W-1:0]         peak_reg;
    logic [BYTE_W-1:0]         tag_usage_reg [NUM_TAGS];
    logic [scpa_pkg::GRANT_W-1:0] grant_reg;

    logic [IDX_W-1:0]  cur_head;
    logic              cur_ok;
    logic [CNT_W-1:0]  cur_fb;
    logic [CNT_W-1:0]  cur_count;
    logic [SLOT_W-1:0] cur_base;
    logic              tag_in;
    logic [TAG_W-1:0]  tag_idx;
    logic [BYTE_W-1:0] cur_tag;
    logic              fidx_ok;
    logic              grant;
    logic              free_ok;
    logic              done_ok;

    assign cur_head  = head_reg[cls_reg];
    assign cur_ok    = head_ok_reg[cls_reg];
    assign cur_fb    = fb_reg[cls_reg];
    assign cur_count = count_tab[cls_reg];
    assign cur_base  = base_tab[cls_reg];
    assign tag_in    = 32'(tag_reg) < 32'(NUM_TAGS);
    assign tag_idx   = TAG_W'(tag_reg);
    assign cur_tag   = tag_in ? tag_usage_reg[tag_idx] : '0;
    assign fidx_ok   = 32'(fidx_reg) < 32'(cur_count);
    assign grant     = found_reg && !req_type_reg && cur_ok;
    assign free_ok   = found_reg && req_type_reg && fidx_ok;
    assign done_ok   = grant || free_ok;

    // link memory: {link valid, next index} per block
    logic [IDX_W:0]    link_mem [LINK_DEPTH];
    logic [IDX_W:0]    rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    logic [IDX_W:0]    mem_wd;
    logic [SLOT_W-1:0] rd_addr;
    logic [IDX_W-1:0]  rd_link;
    logic              rd_ok;

    // clearing pass counters
    logic [SLOT_W-1:0] clr_slot_reg;
    logic [IDX_W-1:0]  clr_idx_reg;
    logic [CLS_W-1:0]  clr_cls_reg;
    logic              clr_last_in_cls;
    logic [IDX_W-1:0]  clr_link;

    assign clr_last_in_cls = (CNT_W'(clr_idx_reg) + CNT_W'(1)) == count_tab[clr_cls_reg];
    assign clr_link        = clr_idx_reg + IDX_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_slot_reg <= '0;
            clr_idx_reg  <= '0;
            clr_cls_reg  <= '0;
        end else if (cmd.clear_step) begin
            clr_slot_reg <= clr_slot_reg + SLOT_W'(1);
            if (clr_last_in_cls) begin
                clr_idx_reg <= '0;
                clr_cls_reg <= clr_cls_reg + CLS_W'(1);
            end else begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
        end
    end

    assign mem_we  = cmd.clear_step || (cmd.finish && free_ok);
    assign mem_wa  = cmd.clear_step ? clr_slot_reg : cur_base + SLOT_W'(fidx_reg);
    assign mem_wd  = cmd.clear_step ? {!clr_last_in_cls, clr_link} : {cur_ok, cur_head};
    assign rd_addr = cur_base + SLOT_W'(cur_head);
    assign rd_link = rd_data_reg[IDX_W-1:0];
    assign rd_ok   = rd_data_reg[IDX_W];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_wa] <= mem_wd;
        end
        if (cmd.read_link) begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    // counter updates
    logic [CNT_W-1:0]  fb_new;
    logic [SUM_W-1:0]  used_sum;
    logic [SUM_W-1:0]  tag_sum;
    logic [BYTE_W-1:0] used_add;
    logic [BYTE_W-1:0] used_sub;
    logic [BYTE_W-1:0] tag_add;
    logic [BYTE_W-1:0] tag_sub;
    logic [BYTE_W-1:0] used_new;
    logic [BYTE_W-1:0] peak_new;
    logic [BYTE_W-1:0] tag_new;

    always_comb begin
        if (grant) begin
            fb_new = (cur_fb != '0) ? cur_fb - CNT_W'(1) : cur_fb;
        end else begin
            fb_new = (cur_fb < cur_count) ? cur_fb + CNT_W'(1) : cur_fb;
        end
        used_sum = {1'b0, used_reg} + SUM_W'(req_size_reg);
        tag_sum  = {1'b0, cur_tag} + SUM_W'(req_size_reg);
        used_add = used_sum[BYTE_W] ? '1 : used_sum[BYTE_W-1:0];
        tag_add  = tag_sum[BYTE_W] ? '1 : tag_sum[BYTE_W-1:0];
        used_sub = (used_reg < BYTE_W'(req_size_reg)) ? '0 : used_reg - BYTE_W'(req_size_reg);
        tag_sub  = (cur_tag < BYTE_W'(req_size_reg)) ? '0 : cur_tag - BYTE_W'(req_size_reg);
        used_new = grant ? used_add : used_sub;
        tag_new  = grant ? tag_add : tag_sub;
        peak_new = (grant && (used_add > peak_reg)) ? used_add : peak_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                head_reg[c]    <= '0;
                head_ok_reg[c] <= (count_tab[c] != '0);
                fb_reg[c]      <= count_tab[c];
            end
            for (int t = 0; t < NUM_TAGS; t++) begin
                tag_usage_reg[t] <= '0;
            end
            used_reg  <= '0;
            peak_reg  <= '0;
            grant_reg <= '0;
        end else if (cmd.finish && done_ok) begin
            head_reg[cls_reg]    <= grant ? rd_link : IDX_W'(fidx_reg);
            head_ok_reg[cls_reg] <= grant ? rd_ok : 1'b1;
            fb_reg[cls_reg]      <= fb_new;
            used_reg             <= used_new;
            peak_reg             <= peak_new;
            if (tag_in) begin
                tag_usage_reg[tag_idx] <= tag_new;
            end
            if (grant) begin
                grant_reg <= grant_reg + scpa_pkg::GRANT_W'(1);
            end
        end
    end

    // result register
    logic                          m_valid_reg;
    scpa_pkg::status_t             status_reg;
    logic [scpa_pkg::CLS_OUT_W-1:0] class_reg;
    logic [scpa_pkg::IDX_OUT_W-1:0] index_reg;
    logic [scpa_pkg::LEFT_W-1:0]    left_reg;
    logic [BYTE_W-1:0]             used_out_reg;
    logic [BYTE_W-1:0]             peak_out_reg;
    logic [BYTE_W-1:0]             tag_out_reg;
    scpa_pkg::status_t             status_next;

    always_comb begin
        if (!found_reg) begin
            status_next = scpa_pkg::STATUS_TOO_LARGE;
        end else if (!req_type_reg) begin
            status_next = grant ? scpa_pkg::STATUS_ALLOC : scpa_pkg::STATUS_EXHAUSTED;
        end else begin
            status_next = free_ok ? scpa_pkg::STATUS_FREED : scpa_pkg::STATUS_BAD_INDEX;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            status_reg <= status_next;
            class_reg  <= scpa_pkg::CLS_OUT_W'(cls_reg);
            if (grant) begin
                index_reg <= scpa_pkg::IDX_OUT_W'(cur_head);
            end else if (free_ok) begin
                index_reg <= fidx_reg;
            end else begin
                index_reg <= '0;
            end
            if (done_ok) begin
                left_reg <= scpa_pkg::LEFT_W'(fb_new);
            end else if (found_reg && req_type_reg) begin
                // rejected free still reports the class's current count
                left_reg <= scpa_pkg::LEFT_W'(cur_fb);
            end else begin
                left_reg <= '0;
            end
            used_out_reg <= done_ok ? used_new : used_reg;
            peak_out_reg <= peak_new;
            if (!tag_in) begin
                tag_out_reg <= '0;
            end else begin
                tag_out_reg <= done_ok ? tag_new : cur_tag;
            end
        end
    end

    // empty classes sit at the top and own no entries, so the pass ends on the last entry
    assign sts.clear_last = clr_slot_reg == SLOT_W'(LINK_DEPTH - 1);
    assign sts.need_pop   = grant;
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_status      = status_reg;
    assign m_block_class = class_reg;
    assign m_block_index = index_reg;
    assign m_blocks_left = left_reg;
    assign m_used_bytes  = used_out_reg;
    assign m_peak_bytes  = peak_out_reg;
    assign m_tag_bytes   = tag_out_reg;

    `SCPA_ASSERT_ALWAYS(a_peak_covers_used, aclk, aresetn, peak_reg >= used_reg, "peak byte total fell below used total")
    `SCPA_ASSERT_ALWAYS(a_one_mem_port, aclk, aresetn, !(mem_we && cmd.read_link), "link memory written and read in one cycle")
    `SCPA_ASSERT_NEXT(a_grant_counted, aclk, aresetn, cmd.finish && grant, grant_reg == $past(grant_reg) + scpa_pkg::GRANT_W'(1), "granted allocation not counted")

endmodule

// ----- sv/size_class_pool_allocator.sv -----
// top level of the size class pool allocator: controller plus datapath
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+---------------------------------------------
//  request   | in        | s_valid / s_ready  | s_req_type s_req_size s_usage_tag s_free_index
//  result    | out       | m_valid / m_ready  | m_status m_block_class m_block_index
//            |           |                    | m_blocks_left m_used_bytes m_peak_bytes m_tag_bytes
//
// a free or a rejected request passes through the accept and execute states; a granted
// allocation adds a pop state for the registered read of the head's link. the result is
// registered once the output register is free, so a pending result can stall it.
// after reset a clearing pass chains every free list, one link memory entry a cycle, over
// 7936 entries at the default sizes (the sum of all class block counts), s_ready low.
// a result waits in the output register while the next transaction is accepted; that
// transaction completes once the register is taken.
module size_class_pool_allocator #(
    parameter int BASE_BLOCKS     = scpa_pkg::BASE_BLOCKS_DEF,
    parameter int NUM_CLASSES     = scpa_pkg::NUM_CLASSES_DEF,
    parameter int MIN_BLOCK_BYTES = scpa_pkg::MIN_BLOCK_BYTES_DEF,
    parameter int NUM_TAGS        = scpa_pkg::NUM_TAGS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [scpa_pkg::SIZE_W-1:0]    s_req_size,
    input  logic [scpa_pkg::TAG_IN_W-1:0]  s_usage_tag,
    input  logic [scpa_pkg::IDX_OUT_W-1:0] s_free_index,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [scpa_pkg::STATUS_W-1:0]  m_status,
    output logic [scpa_pkg::CLS_OUT_W-1:0] m_block_class,
    output logic [scpa_pkg::IDX_OUT_W-1:0] m_block_index,
    output logic [scpa_pkg::LEFT_W-1:0]    m_blocks_left,
    output logic [scpa_pkg::BYTE_W-1:0]    m_used_bytes,
    output logic [scpa_pkg::BYTE_W-1:0]    m_peak_bytes,
    output logic [scpa_pkg::BYTE_W-1:0]    m_tag_bytes
);

    scpa_pkg::dp_cmd_t    cmd;
    scpa_pkg::dp_status_t sts;

    scpa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    scpa_dp #(
        .BASE_BLOCKS     (BASE_BLOCKS),
        .NUM_CLASSES     (NUM_CLASSES),
        .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
        .NUM_TAGS        (NUM_TAGS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_req_type    (s_req_type),
        .s_req_size    (s_req_size),
        .s_usage_tag   (s_usage_tag),
        .s_free_index  (s_free_index),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_status      (m_status),
        .m_block_class (m_block_class),
        .m_block_index (m_block_index),
        .m_blocks_left (m_blocks_left),
        .m_used_bytes  (m_used_bytes),
        .m_peak_bytes  (m_peak_bytes),
        .m_tag_bytes   (m_tag_bytes)
    );

endmodule

// ----- bench/tb.sv -----
// testbench for the size class pool allocator: directed table, random traffic and a class exhaustion run
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SIZE_W       = scpa_pkg::SIZE_W;
    localparam int TAG_IN_W     = scpa_pkg::TAG_IN_W;
    localparam int IDX_OUT_W    = scpa_pkg::IDX_OUT_W;
    localparam int CLS_OUT_W    = scpa_pkg::CLS_OUT_W;
    localparam int LEFT_W       = scpa_pkg::LEFT_W;
    localparam int BYTE_W       = scpa_pkg::BYTE_W;
    localparam int STATUS_W     = scpa_pkg::STATUS_W;
    localparam int POOL_BASE    = scpa_pkg::BASE_BLOCKS_DEF;
    localparam int CLASS_N      = scpa_pkg::NUM_CLASSES_DEF;
    localparam int MIN_BYTES    = scpa_pkg::MIN_BLOCK_BYTES_DEF;
    localparam int TAG_N        = scpa_pkg::NUM_TAGS_DEF;
    localparam int TOP_CLASS    = CLASS_N - 1;
    localparam int BYTE_CEIL    = (1 << BYTE_W) - 1;
    localparam int LINK_SLOTS   = 2 * POOL_BASE;
    localparam int RANDOM_MIXED = 250;
    localparam int DRAIN_BOUND  = 400;
    localparam int STALL_LIMIT  = 40000;
    localparam int END_SLACK    = 16;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    typedef struct {
        scpa_pkg::status_t    status;
        logic [CLS_OUT_W-1:0] cls;
        logic [IDX_OUT_W-1:0] index;
        logic [LEFT_W-1:0]    left;
        logic [BYTE_W-1:0]    used;
        logic [BYTE_W-1:0]    peak;
        logic [BYTE_W-1:0]    tag_total;
    } outcome_t;

    typedef struct {
        logic                 is_free;
        logic [SIZE_W-1:0]    size;
        logic [TAG_IN_W-1:0]  tag;
        logic [IDX_OUT_W-1:0] fidx;
        bit                   typed;
        outcome_t             want;
    } stim_row_t;

    typedef struct {
        int                   cls;
        logic [IDX_OUT_W-1:0] index;
        logic [SIZE_W-1:0]    size;
        logic [TAG_IN_W-1:0]  tag;
    } grant_t;

    logic                 aclk;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_req_type   = REQ_ALLOC;
    logic [SIZE_W-1:0]    s_req_size   = '0;
    logic [TAG_IN_W-1:0]  s_usage_tag  = '0;
    logic [IDX_OUT_W-1:0] s_free_index = '0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic [CLS_OUT_W-1:0] m_block_class;
    logic [IDX_OUT_W-1:0] m_block_index;
    logic [LEFT_W-1:0]    m_blocks_left;
    logic [BYTE_W-1:0]    m_used_bytes;
    logic [BYTE_W-1:0]    m_peak_bytes;
    logic [BYTE_W-1:0]    m_tag_bytes;

    // model of the pools
    logic [IDX_OUT_W-1:0] link_to   [LINK_SLOTS];
    bit                   link_live [LINK_SLOTS];
    logic [IDX_OUT_W-1:0] head_idx  [CLASS_N];
    bit                   head_live [CLASS_N];
    int unsigned          free_cnt  [CLASS_N];
    int unsigned          used_sum;
    int unsigned          peak_sum;
    int unsigned          tag_sum   [TAG_N];

    outcome_t  expected_results [$];
    stim_row_t directed_rows [$];
    grant_t    live_grants [$];

    bit calm = 1'b0;
    int stall_cycles    = 0;
    int mismatches      = 0;
    int results_checked = 0;
    int requests_sent   = 0;
    int status_seen [5] = '{default: 0};

    size_class_pool_allocator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_req_size    (s_req_size),
        .s_usage_tag   (s_usage_tag),
        .s_free_index  (s_free_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_block_class (m_block_class),
        .m_block_index (m_block_index),
        .m_blocks_left (m_blocks_left),
        .m_used_bytes  (m_used_bytes),
        .m_peak_bytes  (m_peak_bytes),
        .m_tag_bytes   (m_tag_bytes)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
    end

    function automatic int class_blocks(input int c);
        return POOL_BASE >> c;
    endfunction

    // classes are packed back to back, each half the size of the one before
    function automatic int class_slot(input int c, input int i);
        return LINK_SLOTS - (LINK_SLOTS >> c) + i;
    endfunction

    function automatic int unsigned bytes_up(input int unsigned a, input int unsigned b);
        return (a + b > BYTE_CEIL) ? BYTE_CEIL : a + b;
    endfunction

    function automatic int unsigned bytes_down(input int unsigned a, input int unsigned b);
        return (b > a) ? 0 : a - b;
    endfunction

    function automatic void pool_reset();
        int n;
        for (int c = 0; c < CLASS_N; c++) begin
            n = class_blocks(c);
            for (int i = 0; i < n; i++) begin
                link_to[class_slot(c, i)]   = IDX_OUT_W'(i + 1);
                link_live[class_slot(c, i)] = (i + 1 < n);
            end
            head_idx[c]  = '0;
            head_live[c] = (n > 0);
            free_cnt[c]  = n;
        end
        used_sum = 0;
        peak_sum = 0;
        for (int t = 0; t < TAG_N; t++) begin
            tag_sum[t] = 0;
        end
    endfunction

    function automatic outcome_t pool_outcome(input logic is_free, input logic [SIZE_W-1:0] size,
                                              input logic [TAG_IN_W-1:0] tag,
                                              input logic [IDX_OUT_W-1:0] fidx);
        outcome_t o;
        int       cls;
        int       slot;
        bit       tag_ok;
        o.status = scpa_pkg::STATUS_TOO_LARGE;
        o.cls    = '0;
        o.index  = '0;
        o.left   = '0;
        tag_ok   = (int'(tag) < TAG_N);
        cls      = -1;
        // smallest class whose block holds the size
        for (int c = CLASS_N - 1; c >= 0; c--) begin
            if (int'(size) <= (MIN_BYTES << c)) cls = c;
        end
        if (cls >= 0) begin
            o.cls = CLS_OUT_W'(cls);
            if (is_free == REQ_ALLOC) begin
                if (!head_live[cls]) begin
                    o.status = scpa_pkg::STATUS_EXHAUSTED;
                end else begin
                    slot           = class_slot(cls, int'(head_idx[cls]));
                    o.index        = head_idx[cls];
                    head_idx[cls]  = link_to[slot];
                    head_live[cls] = link_live[slot];
                    if (free_cnt[cls] > 0) free_cnt[cls]--;
                    o.left   = LEFT_W'(free_cnt[cls]);
                    used_sum = bytes_up(used_sum, size);
                    if (used_sum > peak_sum) peak_sum = used_sum;
                    if (tag_ok) tag_sum[tag] = bytes_up(tag_sum[tag], size);
                    o.status = scpa_pkg::STATUS_ALLOC;
                end
            end else if (int'(fidx) >= class_blocks(cls)) begin
                o.status = scpa_pkg::STATUS_BAD_INDEX;
                o.left   = LEFT_W'(free_cnt[cls]);
            end else begin
                // no double free check: the index is simply pushed again
                slot            = class_slot(cls, int'(fidx));
                link_to[slot]   = head_idx[cls];
                link_live[slot] = head_live[cls];
                head_idx[cls]   = fidx;
                head_live[cls]  = 1'b1;
                if (free_cnt[cls] < class_blocks(cls)) free_cnt[cls]++;
                o.left   = LEFT_W'(free_cnt[cls]);
                o.index  = fidx;
                used_sum = bytes_down(used_sum, size);
                if (tag_ok) tag_sum[tag] = bytes_down(tag_sum[tag], size);
                o.status = scpa_pkg::STATUS_FREED;
            end
        end
        o.used      = BYTE_W'(used_sum);
        o.peak      = BYTE_W'(peak_sum);
        o.tag_total = tag_ok ? BYTE_W'(tag_sum[tag]) : '0;
        return o;
    endfunction

    function automatic int pick_gap();
        return calm ? 0 : int'($urandom_range(0, 6));
    endfunction

    function automatic logic [SIZE_W-1:0] size_in_class(input int c);
        if (c == 0) return SIZE_W'($urandom_range(0, MIN_BYTES));
        return SIZE_W'($urandom_range((MIN_BYTES << (c - 1)) + 1, MIN_BYTES << c));
    endfunction

    function automatic void add_row(input logic is_free, input int size, input int tag,
                                    input int fidx);
        stim_row_t r;
        r.is_free = is_free;
        r.size    = SIZE_W'(size);
        r.tag     = TAG_IN_W'(tag);
        r.fidx    = IDX_OUT_W'(fidx);
        r.typed   = 1'b0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_known(input logic is_free, input int size, input int tag,
                                      input int fidx, input scpa_pkg::status_t st,
                                      input int cls, input int idx, input int left,
                                      input int used, input int peak, input int tagb);
        add_row(is_free, size, tag, fidx);
        directed_rows[$].typed          = 1'b1;
        directed_rows[$].want.status    = st;
        directed_rows[$].want.cls       = CLS_OUT_W'(cls);
        directed_rows[$].want.index     = IDX_OUT_W'(idx);
        directed_rows[$].want.left      = LEFT_W'(left);
        directed_rows[$].want.used      = BYTE_W'(used);
        directed_rows[$].want.peak      = BYTE_W'(peak);
        directed_rows[$].want.tag_total = BYTE_W'(tagb);
    endfunction

    task automatic send_request(input logic is_free, input logic [SIZE_W-1:0] size,
                                input logic [TAG_IN_W-1:0] tag,
                                input logic [IDX_OUT_W-1:0] fidx);
        int       gap;
        outcome_t got;
        grant_t   g;
        if (requests_sent % 48 == 0) calm = ($urandom_range(0, 3) == 0);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= is_free;
        s_req_size   <= size;
        s_usage_tag  <= tag;
        s_free_index <= fidx;
        do @(posedge aclk); while (!(s_valid && s_ready));
        got = pool_outcome(is_free, size, tag, fidx);
        requests_sent++;
        status_seen[int'(got.status)]++;
        if (got.status == scpa_pkg::STATUS_ALLOC) begin
            g.cls   = int'(got.cls);
            g.index = got.index;
            g.size  = size;
            g.tag   = tag;
            live_grants.push_back(g);
        end
        expected_results.push_back(got);
    endtask

    task automatic release_grant(input int k);
        grant_t              g;
        logic [SIZE_W-1:0]   size;
        logic [TAG_IN_W-1:0] tag;
        g = live_grants[k];
        live_grants.delete(k);
        size = ($urandom_range(0, 4) == 0) ? size_in_class(g.cls) : g.size;
        tag  = ($urandom_range(0, 4) == 0) ? TAG_IN_W'($urandom_range(0, TAG_N - 1)) : g.tag;
        send_request(REQ_FREE, size, tag, g.index);
    endtask

    task automatic drain_pending();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
    endtask

    task automatic check_result();
        outcome_t want;
        results_checked++;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result with nothing pending: status %0d class %0d index %0d",
                         m_status, m_block_class, m_block_index);
        end else begin
            want = expected_results.pop_front();
            if (m_status !== want.status || m_block_class !== want.cls ||
                m_block_index !== want.index || m_blocks_left !== want.left ||
                m_used_bytes !== want.used || m_peak_bytes !== want.peak ||
                m_tag_bytes !== want.tag_total) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display({"result %0d expected: st %0d cls %0d idx %0d left %0d",
                              " used %0d peak %0d tag %0d"},
                             results_checked, want.status, want.cls, want.index, want.left,
                             want.used, want.peak, want.tag_total);
                    $display({"result %0d actual:   st %0d cls %0d idx %0d left %0d",
                              " used %0d peak %0d tag %0d"},
                             results_checked, m_status, m_block_class, m_block_index,
                             m_blocks_left, m_used_bytes, m_peak_bytes, m_tag_bytes);
                end
            end
        end
    endtask

    // result side
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            check_result();
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // request side
    initial begin
        stim_row_t row;
        int        pick;
        int        k;
        int        n;
        int        start;
        int        tries;

        pool_reset();
        add_known(REQ_ALLOC, 0, 0, 0, scpa_pkg::STATUS_ALLOC, 0, 0, 4095, 0, 0, 0);
        add_known(REQ_FREE, 20, 0, 0, scpa_pkg::STATUS_FREED, 0, 0, 4096, 0, 0, 0);
        add_known(REQ_ALLOC, 32, 1, 0, scpa_pkg::STATUS_ALLOC, 0, 0, 4095, 32, 32, 32);
        add_known(REQ_ALLOC, 33, 2, 0, scpa_pkg::STATUS_ALLOC, 1, 0, 2047, 65, 65, 33);
        add_known(REQ_ALLOC, 512, 15, 0, scpa_pkg::STATUS_ALLOC, 4, 0, 255, 577, 577, 512);
        add_known(REQ_ALLOC, 513, 3, 4095, scpa_pkg::STATUS_TOO_LARGE, 0, 0, 0, 577, 577, 0);
        add_known(REQ_ALLOC, 4095, 15, 0, scpa_pkg::STATUS_TOO_LARGE, 0, 0, 0, 577, 577, 512);
        add_known(REQ_FREE, 4095, 0, 4095, scpa_pkg::STATUS_TOO_LARGE, 0, 0, 0, 577, 577, 0);
        add_known(REQ_FREE, 512, 15, 256, scpa_pkg::STATUS_BAD_INDEX, 4, 0, 255, 577, 577, 512);
        add_known(REQ_FREE, 256, 5, 512, scpa_pkg::STATUS_BAD_INDEX, 3, 0, 512, 577, 577, 0);
        add_row(REQ_FREE, 32, 1, 4095);
        add_row(REQ_ALLOC, 1, 4, 0);
        add_row(REQ_FREE, 128, 6, 1023);
        add_row(REQ_FREE, 0, 0, 0);
        add_row(REQ_ALLOC, 64, 8, 0);
        add_row(REQ_ALLOC, 65, 9, 0);
        add_row(REQ_ALLOC, 129, 10, 0);
        add_row(REQ_ALLOC, 256, 11, 0);
        add_row(REQ_ALLOC, 257, 12, 0);
        add_row(REQ_FREE, 512, 15, 0);
        add_row(REQ_FREE, 33, 2, 0);
        add_row(REQ_ALLOC, 511, 13, 'hAAA);
        add_row(REQ_FREE, 64, 14, 'h555);
        add_row(REQ_FREE, 128, 9, 1024);

        wait (aresetn);
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            send_request(row.is_free, row.size, row.tag, row.fidx);
            if (row.typed) expected_results[expected_results.size() - 1] = row.want;
        end

        // mixed traffic: mostly allocations and frees of held blocks, some noise
        repeat (RANDOM_MIXED) begin
            pick = $urandom_range(0, 99);
            if (pick >= 85) begin
                send_request(1'($urandom_range(0, 1)), SIZE_W'($urandom_range(0, 4095)),
                             TAG_IN_W'($urandom_range(0, 15)),
                             IDX_OUT_W'($urandom_range(0, 4095)));
            end else if (pick >= 50 && live_grants.size() > 0) begin
                release_grant($urandom_range(0, live_grants.size() - 1));
            end else begin
                k = $urandom_range(0, CLASS_N - 1);
                send_request(REQ_ALLOC,
                             ($urandom_range(0, 24) == 0) ? SIZE_W'($urandom_range(513, 4095))
                                                         : size_in_class(k),
                             TAG_IN_W'($urandom_range(0, 15)),
                             IDX_OUT_W'($urandom_range(0, 4095)));
            end
        end

        // empty the largest class, run into exhaustion, then hand its blocks back
        drain_pending();
        tries = 0;
        while (head_live[TOP_CLASS] && tries < DRAIN_BOUND) begin
            send_request(REQ_ALLOC, size_in_class(TOP_CLASS), TAG_IN_W'($urandom_range(0, 15)),
                         IDX_OUT_W'($urandom_range(0, 4095)));
            tries++;
        end
        repeat (3) send_request(REQ_ALLOC, size_in_class(TOP_CLASS),
                                TAG_IN_W'($urandom_range(0, 15)), '0);
        do begin
            k     = -1;
            n     = live_grants.size();
            start = (n > 0) ? int'($urandom_range(0, n - 1)) : 0;
            for (int j = 0; j < n; j++) begin
                if (k < 0 && live_grants[(start + j) % n].cls == TOP_CLASS) k = (start + j) % n;
            end
            if (k >= 0) release_grant(k);
        end while (k >= 0);

        drain_pending();
        repeat (END_SLACK) @(posedge aclk);
        $display("covered %0d requests: %0d grants, %0d exhausted, %0d oversize, %0d frees, %0d bad index",
                 requests_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        $display("%0d results checked, byte total peaked at %0d, %0d mismatches",
                 results_checked, peak_sum, mismatches);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/scpa_pkg.sv
sv/scpa_ctrl.sv
sv/scpa_dp.sv
sv/size_class_pool_allocator.sv
bench/tb.sv
